[hdl/ndc_pkg.sv]
// Shared types and constants for the nibble delta codec.
`default_nettype none

package ndc_pkg;

  localparam int NUM_CODES   = 16;
  localparam int CODE_W      = 4;
  localparam int SAMPLE_W    = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  // Register map
  localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_LO     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_HI     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_LO = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_HI = 3'd4;

  // Operating modes
  localparam logic MODE_COMPRESS = 1'b0;
  localparam logic MODE_EXPAND   = 1'b1;

  localparam logic [CODE_W-1:0] CODE_TOP = 4'hF;

  typedef struct packed {
    logic                                    mode;
    logic [NUM_CODES-1:0][SAMPLE_W-1:0]      delta;
    logic [NUM_CODES-1:0][SAMPLE_W-1:0]      threshold;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] data;
    logic                run_end;
    logic                block_end;
  } result_t;

  // Results of one item: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_set_t;

  typedef struct packed {
    logic room;        // buffer can absorb a full item
    logic spare_busy;  // second result waits behind the output register
  } buf_status_t;

endpackage

`default_nettype wire

[hdl/nibble_delta_codec.sv]
// Top level of the nibble delta codec: config, datapath, result buffer.
// A result is on out_* in the cycle after its item is accepted.
// One item per cycle while compressing or seeding a block, as long as
//   out_ready holds; an expanded byte yields two samples through one output
//   register, so no new item enters while the second sample waits in the spare slot.
// Reset (rst, synchronous): registers, accumulator and held nibble clear.
`default_nettype none

module nibble_delta_codec
  import ndc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_W-1:0]    in_byte,
  input  wire logic                   block_first,
  input  wire logic                   block_last,
  // result items
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SAMPLE_W-1:0]         out_byte,
  output logic                        run_end,
  output logic                        block_end
);

  cfg_t        cfg;
  result_set_t res;
  buf_status_t status;
  logic        take;

  // An item enters only when the buffer can hold everything it produces;
  // a result leaving this cycle frees its slot for the new one.
  assign in_ready = status.room;
  assign take     = in_valid && in_ready;

  ndc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Single pass: the code search and accumulator update settle within the
  // cycle the item is accepted; the results land in the buffer registers.
  ndc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .in_byte     (in_byte),
    .block_first (block_first),
    .block_last  (block_last),
    .res         (res)
  );

  ndc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res       (res),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .block_end (block_end)
  );

  // The spare slot only fills behind a held head result.
  a_spare_behind_head: assert property (@(posedge clk) disable iff (rst)
    status.spare_busy |-> out_valid)
    else $error("spare result held without a head result");

  // No item may enter while the second sample still waits.
  a_no_take_when_spare: assert property (@(posedge clk) disable iff (rst)
    status.spare_busy |-> !in_ready)
    else $error("input accepted while spare slot occupied");

  // An expanded byte leaves two samples queued.
  a_expand_two_results: assert property (@(posedge clk) disable iff (rst)
    (take && !block_first && cfg.mode == MODE_EXPAND) |=> (out_valid && status.spare_busy))
    else $error("expand item did not queue two samples");

endmodule

`default_nettype wire

[hdl/ndc_cfg.sv]
// Configuration register file of the nibble delta codec.
`default_nettype none

module ndc_cfg
  import ndc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  logic                  mode;
  logic [CFG_DATA_W-1:0] delta_lo;
  logic [CFG_DATA_W-1:0] delta_hi;
  logic [CFG_DATA_W-1:0] threshold_lo;
  logic [CFG_DATA_W-1:0] threshold_hi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_COMPRESS;
      delta_lo     <= '0;
      delta_hi     <= '0;
      threshold_lo <= '0;
      threshold_hi <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:         mode         <= cfg_data[0];
        REG_DELTA_LO:     delta_lo     <= cfg_data;
        REG_DELTA_HI:     delta_hi     <= cfg_data;
        REG_THRESHOLD_LO: threshold_lo <= cfg_data;
        REG_THRESHOLD_HI: threshold_hi <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // code 0 lands in bits 7:0 of the low word
  assign cfg.mode      = mode;
  assign cfg.delta     = {delta_hi, delta_lo};
  assign cfg.threshold = {threshold_hi, threshold_lo};

endmodule

`default_nettype wire

[hdl/ndc_core.sv]
// Codec datapath: accumulator, code search, nibble pairing and expansion.
`default_nettype none

module ndc_core
  import ndc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                take,
  input  wire logic [SAMPLE_W-1:0] in_byte,
  input  wire logic                block_first,
  input  wire logic                block_last,
  output result_set_t              res
);

  logic [SAMPLE_W-1:0] running_value;
  logic [CODE_W-1:0]   held_nibble;
  logic                nibble_waiting;

  logic [SAMPLE_W-1:0] running_value_next;
  logic [CODE_W-1:0]   held_nibble_next;
  logic                nibble_waiting_next;

  logic [SAMPLE_W-1:0] diff;
  logic [CODE_W-1:0]   code;
  logic [SAMPLE_W-1:0] expand_lo;
  logic [SAMPLE_W-1:0] expand_hi;

  // Code search: top code wins at or above its threshold, else lowest code
  // whose threshold covers the difference, else top code.
  always_comb begin
    diff = in_byte - running_value;
    code = CODE_TOP;
    for (int c = NUM_CODES - 2; c >= 0; c--) begin
      if ($signed(diff) <= $signed(cfg.threshold[CODE_W'(c)])) code = CODE_W'(c);
    end
    if ($signed(diff) >= $signed(cfg.threshold[NUM_CODES-1])) code = CODE_TOP;
  end

  assign expand_lo = running_value + cfg.delta[in_byte[CODE_W-1:0]];
  assign expand_hi = expand_lo + cfg.delta[in_byte[SAMPLE_W-1:CODE_W]];

  always_comb begin
    running_value_next  = running_value;
    held_nibble_next    = held_nibble;
    nibble_waiting_next = nibble_waiting;
    res                 = '0;
    if (block_first) begin
      running_value_next  = in_byte;
      held_nibble_next    = '0;
      nibble_waiting_next = 1'b0;
      res.count           = 2'd1;
      res.r0              = '{data: in_byte, run_end: 1'b1, block_end: block_last};
    end else if (cfg.mode == MODE_COMPRESS) begin
      running_value_next = running_value + cfg.delta[code];
      if (nibble_waiting) begin
        held_nibble_next    = '0;
        nibble_waiting_next = 1'b0;
        res.count           = 2'd1;
        res.r0 = '{data: {code, held_nibble}, run_end: 1'b1, block_end: block_last};
      end else if (block_last) begin
        // lone code at block end goes out with an empty high nibble
        res.count = 2'd1;
        res.r0    = '{data: {{CODE_W{1'b0}}, code}, run_end: 1'b1, block_end: 1'b1};
      end else begin
        held_nibble_next    = code;
        nibble_waiting_next = 1'b1;
      end
    end else begin
      running_value_next = expand_hi;
      res.count          = 2'd2;
      res.r0             = '{data: expand_lo, run_end: 1'b0, block_end: 1'b0};
      res.r1             = '{data: expand_hi, run_end: 1'b1, block_end: block_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value  <= '0;
      held_nibble    <= '0;
      nibble_waiting <= 1'b0;
    end else if (take) begin
      running_value  <= running_value_next;
      held_nibble    <= held_nibble_next;
      nibble_waiting <= nibble_waiting_next;
    end
  end

endmodule

`default_nettype wire

[hdl/ndc_outbuf.sv]
// Result register with one spare slot for the second expanded sample.
`default_nettype none

module ndc_outbuf
  import ndc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire result_set_t          res,
  output buf_status_t               status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SAMPLE_W-1:0]       out_byte,
  output logic                      run_end,
  output logic                      block_end
);

  result_t head;
  result_t spare;
  logic    spare_valid;
  logic    fire;

  assign fire              = out_valid && out_ready;
  assign status.room       = !spare_valid && (!out_valid || out_ready);
  assign status.spare_busy = spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (take && res.count != 2'd0) begin
      out_valid   <= 1'b1;
      spare_valid <= (res.count == 2'd2);
    end else if (fire) begin
      out_valid   <= spare_valid;
      spare_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.count != 2'd0) begin
      head  <= res.r0;
      spare <= res.r1;
    end else if (fire) begin
      head  <= spare;
    end
  end

  assign out_byte  = head.data;
  assign run_end   = head.run_end;
  assign block_end = head.block_end;

endmodule

`default_nettype wire
